@@ src/pnpl_pkg.sv @@
`timescale 1ns / 1ps

package pnpl_pkg;

	// Field widths fixed by the interface
	localparam int POS_W      = 24;
	localparam int CURV_W     = 32;
	localparam int IDX_W      = 10;
	localparam int DIST_OUT_W = 48;
	localparam int COUNT_W    = 11;

	// Internal distance width: holds three 48-bit squares and the search bound
	localparam int SUM_W  = 50;
	localparam int DIST_W = 56;

	// Defaults for the top-level parameters
	localparam int MAX_POINTS_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 2'd3;

	localparam logic [POS_W-1:0]   BOX_RESET    = 24'd655360;
	localparam logic [COUNT_W-1:0] POINTS_RESET = 11'd1;

	// Request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic                     req_type;
		logic [IDX_W-1:0]         entry_index;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic [POS_W-1:0]         pos_z;
		logic signed [CURV_W-1:0] curvature_in;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]         closest_index;
		logic [DIST_OUT_W-1:0]    best_dist_sq;
		logic signed [CURV_W-1:0] curvature_out;
		logic                     far_flag;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0]   box_x;
		logic [POS_W-1:0]   box_y;
		logic [POS_W-1:0]   box_z;
		logic [COUNT_W-1:0] points_in_use;
	} cfg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic fetch;
		logic load_out;
	} cmd_t;

	// Initial search bound: 20000 nm^2 at 2*frac fractional bits
	function automatic logic [DIST_W-1:0] bound_sq(input int frac);
		logic [DIST_W-1:0] base;
		base = DIST_W'(20000);
		return base << (2 * frac);
	endfunction

	// Far threshold: 4 nm^2 at 2*frac fractional bits
	function automatic logic [DIST_W-1:0] far_sq(input int frac);
		logic [DIST_W-1:0] base;
		base = DIST_W'(4);
		return base << (2 * frac);
	endfunction

endpackage

@@ src/pnpl_cfg.sv @@
`timescale 1ns / 1ps

module pnpl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pnpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pnpl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output pnpl_pkg::cfg_t                   cfg
);

	pnpl_pkg::cfg_t cfg_q;

	// Decode the register index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x         <= pnpl_pkg::BOX_RESET;
			cfg_q.box_y         <= pnpl_pkg::BOX_RESET;
			cfg_q.box_z         <= pnpl_pkg::BOX_RESET;
			cfg_q.points_in_use <= pnpl_pkg::POINTS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pnpl_pkg::REG_BOX_X: cfg_q.box_x <= cfg_data;
				pnpl_pkg::REG_BOX_Y: cfg_q.box_y <= cfg_data;
				pnpl_pkg::REG_BOX_Z: cfg_q.box_z <= cfg_data;
				pnpl_pkg::REG_POINTS_IN_USE: begin
					cfg_q.points_in_use <= cfg_data[pnpl_pkg::COUNT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/pnpl_ctrl.sv @@
`timescale 1ns / 1ps

module pnpl_ctrl #(
	parameter int MAX_POINTS = pnpl_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_type,
	output logic                                req_stall,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic [pnpl_pkg::COUNT_W-1:0]        points_in_use,
	input  logic                                pipe_busy,
	output pnpl_pkg::cmd_t                      cmd,
	output logic [$clog2(MAX_POINTS)-1:0]       scan_addr
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_FETCH  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] scan_count;
	logic          accept;
	logic          rsp_valid_q;
	logic          out_free;

	// Clamp the scan length at the table depth
	assign scan_count = (32'(points_in_use) > MAX_POINTS) ? CW'(MAX_POINTS)
	                                                      : CW'(points_in_use);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign scan_addr = cnt_q[IW-1:0];

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (req_type == pnpl_pkg::REQ_LOAD);
		cmd.start    = accept && (req_type == pnpl_pkg::REQ_QUERY);
		cmd.issue    = (state_q == ST_SCAN) && (cnt_q < scan_count);
		cmd.fetch    = (state_q == ST_FETCH);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!cmd.issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, scan counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ src/pnpl_dp.sv @@
`timescale 1ns / 1ps

module pnpl_dp #(
	parameter int MAX_POINTS = pnpl_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = pnpl_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pnpl_pkg::req_t                  req,
	input  pnpl_pkg::cfg_t                  cfg,
	input  pnpl_pkg::cmd_t                  cmd,
	input  logic [$clog2(MAX_POINTS)-1:0]   scan_addr,
	output logic                            pipe_busy,
	output pnpl_pkg::rsp_t                  rsp
);

	localparam int IW     = $clog2(MAX_POINTS);
	localparam int PW     = pnpl_pkg::POS_W;
	localparam int DW     = pnpl_pkg::DIST_W;
	localparam int SW     = pnpl_pkg::SUM_W;
	localparam logic [DW-1:0] BOUND = pnpl_pkg::bound_sq(FRAC_BITS);
	localparam logic [DW-1:0] FAR   = pnpl_pkg::far_sq(FRAC_BITS);

	// Point table: positions packed x, y, z; curvature apart
	logic [3*PW-1:0]                    pos_mem [MAX_POINTS];
	logic [pnpl_pkg::CURV_W-1:0]        curv_mem [MAX_POINTS];

	logic [PW-1:0]             query_q [3];
	logic [PW-1:0]             box [3];
	logic [DW-1:0]             best_q;
	logic [IW-1:0]             best_idx_q;
	logic [pnpl_pkg::CURV_W-1:0] curv_rd_q;
	pnpl_pkg::rsp_t            rsp_q;

	logic [3*PW-1:0]           pos_s1;
	logic [PW-1:0]             pnt_s1 [3];
	logic signed [PW:0]        diff_s2 [3];
	logic                      wrap_s2 [3];
	logic [PW-1:0]             mag_s3 [3];
	logic [2*PW-1:0]           sq_s4 [3];
	logic [SW-1:0]             sum_s5;
	logic [IW-1:0]             idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                      load_ok;
	logic [IW-1:0]             wr_addr;

	assign box[0] = cfg.box_x;
	assign box[1] = cfg.box_y;
	assign box[2] = cfg.box_z;

	assign load_ok = cmd.load && (32'(req.entry_index) < MAX_POINTS);
	assign wr_addr = IW'(req.entry_index);

	// Write on load, read positions during the scan and the best entry's curvature on fetch
	always_ff @(posedge clk) begin
		if (load_ok) begin
			pos_mem[wr_addr]  <= {req.pos_x, req.pos_y, req.pos_z};
			curv_mem[wr_addr] <= req.curvature_in;
		end
		if (cmd.issue) begin
			pos_s1 <= pos_mem[scan_addr];
		end
		if (cmd.fetch) begin
			curv_rd_q <= curv_mem[best_idx_q];
		end
	end

	assign pnt_s1[0] = pos_s1[3*PW-1:2*PW];
	assign pnt_s1[1] = pos_s1[2*PW-1:PW];
	assign pnt_s1[2] = pos_s1[PW-1:0];

	// Per-axis minimum-image difference and square
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [PW:0]   diff;
		logic [PW:0]          diff_abs;
		logic signed [PW+1:0] diff_w;
		logic signed [PW+1:0] box_w;
		logic signed [PW+1:0] adj;
		logic [PW+1:0]        adj_abs;

		// Raw difference and its magnitude for the wrap decision
		always_comb begin
			diff     = $signed({1'b0, query_q[a]}) - $signed({1'b0, pnt_s1[a]});
			diff_abs = diff[PW] ? (PW+1)'(0) - diff : diff;
		end

		// Fold into the nearest image
		always_comb begin
			diff_w  = {diff_s2[a][PW], diff_s2[a]};
			box_w   = $signed({2'b00, box[a]});
			adj     = diff_w;
			if (wrap_s2[a]) begin
				adj = diff_w[PW+1] ? diff_w + box_w : diff_w - box_w;
			end
			adj_abs = adj[PW+1] ? (PW+2)'(0) - adj : adj;
		end

		always_ff @(posedge clk) begin
			if (cmd.start) begin
				query_q[a] <= (a == 0) ? req.pos_x : (a == 1) ? req.pos_y : req.pos_z;
			end
			diff_s2[a] <= diff;
			wrap_s2[a] <= {diff_abs[PW-1:0], 1'b0} > {1'b0, box[a]};
			mag_s3[a]  <= adj_abs[PW-1:0];
			sq_s4[a]   <= mag_s3[a] * mag_s3[a];
		end
	end

	// Add the three axes and keep the running minimum
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		idx_s5 <= idx_s4;
		sum_s5 <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		if (cmd.start) begin
			best_q     <= BOUND;
			best_idx_q <= '0;
		end else if (vld_s5 && (DW'(sum_s5) < best_q)) begin
			best_q     <= DW'(sum_s5);
			best_idx_q <= idx_s5;
		end
	end

	// Advance the valid tags along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign pipe_busy = vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;

	// Capture the result into the output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.closest_index <= pnpl_pkg::IDX_W'(best_idx_q);
			rsp_q.best_dist_sq  <= best_q[pnpl_pkg::DIST_OUT_W-1:0];
			rsp_q.curvature_out <= curv_rd_q;
			rsp_q.far_flag      <= best_q > FAR;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ src/periodic_nearest_point_lookup.sv @@
// Loads: a load is written in its transfer and leaves the block free to take another request.
// Queries: after a query transfer the block scans N = min(points_in_use, MAX_POINTS) entries
//   of the point table, one entry per cycle, drains the pipeline, fetches the curvature and
//   loads the result; it takes no new request until then, and a stalled earlier result holds it until taken.
// Reset: arst_n clears the controller and loads the box and count registers;
//   the point table is not cleared.
`timescale 1ns / 1ps

module periodic_nearest_point_lookup #(
	parameter int MAX_POINTS = pnpl_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = pnpl_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  pnpl_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output pnpl_pkg::rsp_t                   rsp,
	input  logic                             cfg_wr_en,
	input  logic [pnpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pnpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW = $clog2(MAX_POINTS);

	pnpl_pkg::cfg_t cfg;
	pnpl_pkg::cmd_t cmd;
	logic [IW-1:0]  scan_addr;
	logic           pipe_busy;

	pnpl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pnpl_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_type      (req.req_type),
		.req_stall     (req_stall),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.points_in_use (cfg.points_in_use),
		.pipe_busy     (pipe_busy),
		.cmd           (cmd),
		.scan_addr     (scan_addr)
	);

	pnpl_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.cmd       (cmd),
		.scan_addr (scan_addr),
		.pipe_busy (pipe_busy),
		.rsp       (rsp)
	);

endmodule

@@ src/pnpl_checker.sv @@
`timescale 1ns / 1ps

module pnpl_checker #(
	parameter int FRAC_BITS = pnpl_pkg::FRAC_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_stall,
	input pnpl_pkg::req_t                   req,
	input logic                             rsp_valid,
	input logic                             rsp_stall,
	input pnpl_pkg::rsp_t                   rsp
);

	localparam logic [pnpl_pkg::DIST_W-1:0] FAR = pnpl_pkg::far_sq(FRAC_BITS);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// A query transfer occupies the block on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.req_type == pnpl_pkg::REQ_QUERY) |=> req_stall)
		else $error("block free right after a query transfer");

	// A load transfer leaves the block free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.req_type == pnpl_pkg::REQ_LOAD) |=> !req_stall)
		else $error("block stalled after a load transfer");

	// A near result lies within the far threshold
	a_far_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.far_flag |->
			pnpl_pkg::DIST_W'(rsp.best_dist_sq) <= FAR)
		else $error("far flag clear on a far result");

endmodule

bind periodic_nearest_point_lookup pnpl_checker #(.FRAC_BITS(FRAC_BITS)) u_pnpl_checker (.*);

@@ dv/tb_periodic_nearest_point_lookup.sv @@
`timescale 1ns / 1ps

module tb_periodic_nearest_point_lookup;

	localparam int          TABLE_DEPTH   = 1024;
	localparam int          FILL_SLOTS    = 160;
	localparam int          RANDOM_ITEMS  = 400;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          END_CYCLES    = 1100;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam logic [63:0] BOUND_SQ      = 64'd20000 << 32;
	localparam logic [63:0] FAR_SQ        = 64'd4 << 32;

	typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e                        kind;
		logic [pnpl_pkg::IDX_W-1:0]       slot;
		logic [pnpl_pkg::POS_W-1:0]       x;
		logic [pnpl_pkg::POS_W-1:0]       y;
		logic [pnpl_pkg::POS_W-1:0]       z;
		logic [pnpl_pkg::CURV_W-1:0]      curv;
		logic [pnpl_pkg::CFG_IDX_W-1:0]   cfg_reg;
		logic [pnpl_pkg::CFG_DATA_W-1:0]  cfg_val;
		bit                               typed;
		pnpl_pkg::rsp_t                   want;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	pnpl_pkg::req_t                  req;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	pnpl_pkg::rsp_t                  rsp;
	logic                            cfg_wr_en;
	logic [pnpl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pnpl_pkg::CFG_DATA_W-1:0] cfg_data;

	// Local copy of the point table and the settings
	logic [pnpl_pkg::POS_W-1:0]   pt_x    [TABLE_DEPTH];
	logic [pnpl_pkg::POS_W-1:0]   pt_y    [TABLE_DEPTH];
	logic [pnpl_pkg::POS_W-1:0]   pt_z    [TABLE_DEPTH];
	logic [pnpl_pkg::CURV_W-1:0]  pt_curv [TABLE_DEPTH];
	logic [pnpl_pkg::POS_W-1:0]   box_x_m = pnpl_pkg::BOX_RESET;
	logic [pnpl_pkg::POS_W-1:0]   box_y_m = pnpl_pkg::BOX_RESET;
	logic [pnpl_pkg::POS_W-1:0]   box_z_m = pnpl_pkg::BOX_RESET;
	logic [pnpl_pkg::COUNT_W-1:0] pts_m   = pnpl_pkg::POINTS_RESET;

	pnpl_pkg::rsp_t awaited_nearest [$];
	dir_row_t       dir_rows [$];
	int             mismatch_count = 0;
	int             burst_left     = 0;
	int             stall_left     = 0;
	int             stall_mode     = 0;
	int unsigned    cycle_count    = 0;

	periodic_nearest_point_lookup u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Squared minimum-image difference along one axis
	function automatic logic [63:0] wrapped_sq(input logic [pnpl_pkg::POS_W-1:0] q,
			input logic [pnpl_pkg::POS_W-1:0] p, input logic [pnpl_pkg::POS_W-1:0] box);
		longint d;
		longint mag;
		longint bx;
		d   = longint'(q) - longint'(p);
		bx  = longint'(box);
		mag = (d < 0) ? -d : d;
		if (2 * mag > bx) begin
			if (d < 0)
				d = d + bx;
			else if (d > 0)
				d = d - bx;
		end
		mag = (d < 0) ? -d : d;
		return 64'(mag * mag);
	endfunction

	// Scan the entries in use; strict compare keeps the lowest index on a tie
	function automatic pnpl_pkg::rsp_t nearest_point(input pnpl_pkg::req_t q);
		logic [63:0]                best;
		logic [63:0]                d2;
		logic [pnpl_pkg::IDX_W-1:0] best_idx;
		int                         scan;
		pnpl_pkg::rsp_t             r;
		best     = BOUND_SQ;
		best_idx = '0;
		scan     = (int'(pts_m) > TABLE_DEPTH) ? TABLE_DEPTH : int'(pts_m);
		for (int i = 0; i < scan; i++) begin
			d2 = wrapped_sq(q.pos_x, pt_x[i], box_x_m)
			   + wrapped_sq(q.pos_y, pt_y[i], box_y_m)
			   + wrapped_sq(q.pos_z, pt_z[i], box_z_m);
			if (d2 < best) begin
				best     = d2;
				best_idx = pnpl_pkg::IDX_W'(i);
			end
		end
		r.closest_index = best_idx;
		r.best_dist_sq  = best[pnpl_pkg::DIST_OUT_W-1:0];
		r.curvature_out = pt_curv[best_idx];
		r.far_flag      = (best > FAR_SQ);
		return r;
	endfunction

	function automatic void add_load(input logic [pnpl_pkg::IDX_W-1:0] slot,
			input logic [pnpl_pkg::POS_W-1:0] x, y, z,
			input logic [pnpl_pkg::CURV_W-1:0] curv);
		dir_row_t r;
		r = '{kind: ROW_LOAD, slot: slot, x: x, y: y, z: z, curv: curv,
			cfg_reg: '0, cfg_val: '0, typed: 1'b0, want: '0};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_query(input logic [pnpl_pkg::POS_W-1:0] x, y, z);
		dir_row_t r;
		r = '{kind: ROW_QUERY, slot: '0, x: x, y: y, z: z, curv: '0,
			cfg_reg: '0, cfg_val: '0, typed: 1'b0, want: '0};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_query_typed(input logic [pnpl_pkg::POS_W-1:0] x, y, z,
			input logic [pnpl_pkg::IDX_W-1:0] idx,
			input logic [pnpl_pkg::DIST_OUT_W-1:0] dist_sq,
			input logic [pnpl_pkg::CURV_W-1:0] curv, input logic far);
		dir_row_t r;
		r = '{kind: ROW_QUERY, slot: '0, x: x, y: y, z: z, curv: '0,
			cfg_reg: '0, cfg_val: '0, typed: 1'b1, want: '{idx, dist_sq, curv, far}};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	function automatic void add_cfg(input logic [pnpl_pkg::CFG_IDX_W-1:0] idx,
			input logic [pnpl_pkg::CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '{kind: ROW_CFG, slot: '0, x: '0, y: '0, z: '0, curv: '0,
			cfg_reg: idx, cfg_val: val, typed: 1'b0, want: '0};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Small signed offset around a coordinate, wrapping at the field width
	function automatic logic [pnpl_pkg::POS_W-1:0] jitter(
			input logic [pnpl_pkg::POS_W-1:0] c);
		int delta;
		int off;
		case ($urandom_range(0, 2))
			0:       delta = 0;
			1:       delta = 1 << 16;
			default: delta = 3 << 16;
		endcase
		off = int'($urandom_range(0, 2 * delta)) - delta;
		return pnpl_pkg::POS_W'(int'(c) + off);
	endfunction

	function automatic logic [pnpl_pkg::POS_W-1:0] pick_coord(
			input logic [pnpl_pkg::POS_W-1:0] box);
		if (box != '0 && $urandom_range(0, 1) == 0)
			return pnpl_pkg::POS_W'($urandom_range(0, box - 1));
		return pnpl_pkg::POS_W'($urandom_range(0, 24'hFF_FFFF));
	endfunction

	// Build one item; a non-negative anchor places it near that table entry
	function automatic pnpl_pkg::req_t make_item(input logic kind, input int slot,
			input int anchor);
		pnpl_pkg::req_t r;
		r.req_type     = kind;
		r.entry_index  = pnpl_pkg::IDX_W'(slot);
		r.curvature_in = $urandom();
		if (anchor >= 0) begin
			r.pos_x = jitter(pt_x[anchor]);
			r.pos_y = jitter(pt_y[anchor]);
			r.pos_z = jitter(pt_z[anchor]);
		end else begin
			r.pos_x = pick_coord(box_x_m);
			r.pos_y = pick_coord(box_y_m);
			r.pos_z = pick_coord(box_z_m);
		end
		return r;
	endfunction

	function automatic logic [pnpl_pkg::POS_W-1:0] pick_box();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return pnpl_pkg::POS_W'(1);
			2:       return 24'hFF_FFFF;
			3:       return pnpl_pkg::BOX_RESET;
			4, 5:    return pnpl_pkg::POS_W'($urandom_range(1, 24'hFF_FFFF));
			default: return pnpl_pkg::POS_W'($urandom_range(131072, 2621440));
		endcase
	endfunction

	// Mostly short scans; now and then none or the whole filled region
	function automatic logic [pnpl_pkg::COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 24))
			0:          return '0;
			1:          return pnpl_pkg::COUNT_W'(FILL_SLOTS);
			2:          return pnpl_pkg::COUNT_W'($urandom_range(65, FILL_SLOTS));
			3:          return pnpl_pkg::COUNT_W'($urandom_range(13, 64));
			4:          return pnpl_pkg::COUNT_W'(1);
			5, 6, 7, 8: return pnpl_pkg::COUNT_W'($urandom_range(2, 64));
			default:    return pnpl_pkg::COUNT_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Drive one transfer after an optional gap; on acceptance update the local table or queue the expected result
	task automatic send_req(input pnpl_pkg::req_t item, input bit typed,
			input pnpl_pkg::rsp_t want);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(10, 40);
			end else begin
				burst_left = $urandom_range(1, 12);
				gap        = $urandom_range(1, 8);
			end
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do begin
			@(posedge clk);
		end while (req_stall);
		burst_left--;
		if (item.req_type == pnpl_pkg::REQ_QUERY) begin
			awaited_nearest.insert(awaited_nearest.size(),
				typed ? want : nearest_point(item));
		end else begin
			pt_x[item.entry_index]    = item.pos_x;
			pt_y[item.entry_index]    = item.pos_y;
			pt_z[item.entry_index]    = item.pos_z;
			pt_curv[item.entry_index] = item.curvature_in;
		end
	endtask

	// Hold off until every awaited result is in and the block has gone quiet
	task automatic settle_idle();
		req_valid <= 1'b0;
		while (awaited_nearest.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [pnpl_pkg::CFG_IDX_W-1:0] idx,
			input logic [pnpl_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			pnpl_pkg::REG_BOX_X:         box_x_m = val;
			pnpl_pkg::REG_BOX_Y:         box_y_m = val;
			pnpl_pkg::REG_BOX_Z:         box_z_m = val;
			pnpl_pkg::REG_POINTS_IN_USE: pts_m   = val[pnpl_pkg::COUNT_W-1:0];
			default:                     ;
		endcase
	endtask

	task automatic check_rsp(input pnpl_pkg::rsp_t got);
		pnpl_pkg::rsp_t want;
		if (awaited_nearest.size() == 0) begin
			$error("unexpected result: closest_index %0d", got.closest_index);
			mismatch_count++;
		end else begin
			want = awaited_nearest.pop_front();
			if (got.closest_index !== want.closest_index) begin
				$error("closest_index: expected %0d, got %0d",
					want.closest_index, got.closest_index);
				mismatch_count++;
			end
			if (got.best_dist_sq !== want.best_dist_sq) begin
				$error("best_dist_sq: expected %0d, got %0d",
					want.best_dist_sq, got.best_dist_sq);
				mismatch_count++;
			end
			if (got.curvature_out !== want.curvature_out) begin
				$error("curvature_out: expected %0d, got %0d",
					want.curvature_out, got.curvature_out);
				mismatch_count++;
			end
			if (got.far_flag !== want.far_flag) begin
				$error("far_flag: expected %0d, got %0d", want.far_flag, got.far_flag);
				mismatch_count++;
			end
		end
	endtask

	// Check each result transfer, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_rsp(rsp);
		if (stall_left == 0) begin
			stall_left = $urandom_range(8, 160);
			stall_mode = $urandom_range(0, 3);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= ($urandom_range(0, 1) == 0);
			default: rsp_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		dir_row_t       row;
		pnpl_pkg::req_t item;
		pnpl_pkg::rsp_t no_want;
		bit             cfg_open;
		int             sent;
		int             phase_len;
		int             eff;
		int             anchor;
		bit             wide;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		no_want   = '0;
		cfg_open  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 10 nm box, one point in use
		add_load(10'd0, 24'd0, 24'd0, 24'd0, 32'h7FFF_FFFF);
		add_query_typed(24'd0, 24'd0, 24'd0, 10'd0, 48'd0, 32'h7FFF_FFFF, 1'b0);
		// exactly half a box on every axis stays unwrapped
		add_query_typed(24'd327680, 24'd327680, 24'd327680,
			10'd0, 48'd322122547200, 32'h7FFF_FFFF, 1'b1);
		add_query(24'd327681, 24'd0, 24'd0);
		// exactly 4 nm^2 is not far, one step more is
		add_query_typed(24'd131072, 24'd0, 24'd0, 10'd0, 48'd17179869184,
			32'h7FFF_FFFF, 1'b0);
		add_query(24'd131073, 24'd0, 24'd0);
		add_query(24'd0, 24'hFF_FFFF, 24'd400000);
		// corner entry: nothing under the bound
		add_load(10'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'h8000_0000);
		add_query_typed(24'd0, 24'd0, 24'd0, 10'd0, 48'd85899345920000,
			32'h8000_0000, 1'b1);
		// zero points in use: even an exact match reports the bound
		add_cfg(pnpl_pkg::REG_POINTS_IN_USE, 24'd0);
		add_query_typed(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 10'd0,
			48'd85899345920000, 32'h8000_0000, 1'b1);
		// widest box, unit box and zero box across the axes
		add_cfg(pnpl_pkg::REG_BOX_X, 24'hFF_FFFF);
		add_cfg(pnpl_pkg::REG_BOX_Y, 24'd1);
		add_cfg(pnpl_pkg::REG_BOX_Z, 24'd0);
		add_cfg(pnpl_pkg::REG_POINTS_IN_USE, 24'd4);
		add_load(10'd1, 24'd100, 24'd200, 24'd300, 32'h0000_0000);
		add_load(10'd2, 24'd100, 24'd200, 24'd300, 32'h0000_0001);
		add_load(10'd3, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);
		add_load(10'd0, 24'h80_0000, 24'h80_0000, 24'h80_0000, 32'h0001_2345);
		add_load(10'd1023, 24'h7F_FFFF, 24'h55_5555, 24'hAA_AAAA, 32'h5A5A_A5A5);
		// tie between two identical entries: lower index wins
		add_query_typed(24'd100, 24'd200, 24'd300, 10'd1, 48'd0, 32'h0000_0000, 1'b0);
		add_query(24'd0, 24'd0, 24'd0);
		add_query(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		add_query(24'h7F_FFFF, 24'h80_0001, 24'h7F_FFFF);

		// Walk the directed table; settle before each group of register writes
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				if (!cfg_open) begin
					settle_idle();
					cfg_open = 1'b1;
				end
				write_cfg(row.cfg_reg, row.cfg_val);
			end else begin
				if (cfg_open) begin
					cfg_wr_en <= 1'b0;
					cfg_open  = 1'b0;
				end
				item.req_type     = (row.kind == ROW_QUERY) ? pnpl_pkg::REQ_QUERY
				                                            : pnpl_pkg::REQ_LOAD;
				item.entry_index  = row.slot;
				item.pos_x        = row.x;
				item.pos_y        = row.y;
				item.pos_z        = row.z;
				item.curvature_in = row.curv;
				send_req(item, row.typed, row.want);
			end
		end

		// Fill every slot that a random count can reach
		for (int s = 0; s < FILL_SLOTS; s++) begin
			anchor = (s > 0 && $urandom_range(0, 1) == 0) ? $urandom_range(0, s - 1) : -1;
			send_req(make_item(pnpl_pkg::REQ_LOAD, s, anchor), 1'b0, no_want);
		end

		// Random phases: new settings, then loads mixed with queries near stored points
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_idle();
			write_cfg(pnpl_pkg::REG_BOX_X, pick_box());
			write_cfg(pnpl_pkg::REG_BOX_Y, pick_box());
			write_cfg(pnpl_pkg::REG_BOX_Z, pick_box());
			write_cfg(pnpl_pkg::REG_POINTS_IN_USE, pnpl_pkg::CFG_DATA_W'(pick_count()));
			cfg_wr_en <= 1'b0;
			eff       = (int'(pts_m) > TABLE_DEPTH) ? TABLE_DEPTH : int'(pts_m);
			eff       = (eff == 0) ? 1 : eff;
			wide      = (eff > 64);
			phase_len = wide ? 5 : $urandom_range(6, 30);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				anchor = ($urandom_range(0, 9) < 6) ? $urandom_range(0, eff - 1) : -1;
				if ($urandom_range(0, 99) < (wide ? 60 : 50)) begin
					item = make_item(pnpl_pkg::REQ_LOAD, ($urandom_range(0, 9) < 7) ?
						$urandom_range(0, eff - 1) : $urandom_range(0, TABLE_DEPTH - 1),
						($urandom_range(0, 9) < 4) ? anchor : -1);
				end else begin
					item = make_item(pnpl_pkg::REQ_QUERY,
						$urandom_range(0, TABLE_DEPTH - 1), anchor);
				end
				send_req(item, 1'b0, no_want);
				sent++;
			end
		end

		// Drain, then watch for stray results over one full scan
		req_valid <= 1'b0;
		while (awaited_nearest.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
